>>> hdl/mplc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_pkg
// Shared types and constants for the multi-phase level classifier.
// ----------------------------------------------------------------------------
package mplc_pkg;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_W     = 3;
  localparam int COUNT_W     = 4;
  localparam int CHAN_W      = 16;
  localparam int LEVEL_W     = 8;
  localparam int CODE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CODE_W-1:0] PHASE_BASE = 8'h80;
  localparam logic [CODE_W-1:0] CODE_NONE  = 8'h00;

  // brightness weights and product widths
  localparam int W_RED   = 60;
  localparam int W_GREEN = 118;
  localparam int W_BLUE  = 22;
  localparam int PR_W    = 22;
  localparam int PG_W    = 23;
  localparam int PB_W    = 21;
  localparam int SUM_W   = 24;

  // (sum / 200) >> 8 == (sum >> 11) / 25 ; /25 done by reciprocal multiply
  localparam int LUMA_SHIFT  = 11;
  localparam int X_W         = SUM_W - LUMA_SHIFT;
  localparam int RECIP_MULT  = 41944;
  localparam int RECIP_SHIFT = 20;
  localparam int Q_W         = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE   = 3'd0,
    CFG_PHASE_COUNT  = 3'd1,
    CFG_PHASE_ENABLE = 3'd2,
    CFG_PHASE_LOWS   = 3'd3,
    CFG_PHASE_HIGHS  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                  count;
    logic [NUM_PHASES-1:0]               enable;
    logic [NUM_PHASES-1:0][LEVEL_W-1:0]  lows;
    logic [NUM_PHASES-1:0][LEVEL_W-1:0]  highs;
  } phase_cfg_t;

  typedef struct packed {
    logic               mask;
    logic [LEVEL_W-1:0] level;
  } lvl_t;

endpackage

>>> hdl/mplc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_in_if
// Pixel input channel: valid/ready handshake with mask bit and three channels.
// ----------------------------------------------------------------------------
interface mplc_in_if
  import mplc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              pixel_valid;
  logic [CHAN_W-1:0] chan_red;
  logic [CHAN_W-1:0] chan_green;
  logic [CHAN_W-1:0] chan_blue;

  modport source (output valid, output pixel_valid, output chan_red,
                  output chan_green, output chan_blue, input ready);
  modport sink   (input valid, input pixel_valid, input chan_red,
                  input chan_green, input chan_blue, output ready);
endinterface

>>> hdl/mplc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_out_if
// Result channel: valid/ready handshake carrying the phase code.
// ----------------------------------------------------------------------------
interface mplc_out_if
  import mplc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] phase_code;

  modport source (output valid, output phase_code, input ready);
  modport sink   (input valid, input phase_code, output ready);
endinterface

>>> hdl/mplc_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_level
// Three-stage level pipeline: weighted products, sum and scale, reciprocal
// divide by 25. Selects gray or brightness level at the output.
// ----------------------------------------------------------------------------
module mplc_level
  import mplc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        color_mode,
  mplc_in_if.sink     in_pix,
  output logic        lvl_valid,
  input  logic        lvl_ready,
  output lvl_t        lvl
);

  logic                v1_r, v2_r, v3_r;
  logic                rdy1, rdy2, rdy3;
  logic                mask1_r, mask2_r, mask3_r;
  logic [LEVEL_W-1:0]  gray1_r, gray2_r, gray3_r;
  logic [PR_W-1:0]     pr_r;
  logic [PG_W-1:0]     pg_r;
  logic [PB_W-1:0]     pb_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [X_W-1:0]      x2_r;
  logic [Q_W-1:0]      q3_r;

  assign rdy3 = !v3_r || lvl_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pix.ready = rdy1;

  assign sum_nxt = SUM_W'(pr_r) + SUM_W'(pg_r) + SUM_W'(pb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pix.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mask1_r <= in_pix.pixel_valid;
      gray1_r <= in_pix.chan_red[CHAN_W-1 -: LEVEL_W];
      pr_r    <= PR_W'(in_pix.chan_red)   * PR_W'(W_RED);
      pg_r    <= PG_W'(in_pix.chan_green) * PG_W'(W_GREEN);
      pb_r    <= PB_W'(in_pix.chan_blue)  * PB_W'(W_BLUE);
    end
    if (rdy2) begin
      mask2_r <= mask1_r;
      gray2_r <= gray1_r;
      x2_r    <= sum_nxt[SUM_W-1:LUMA_SHIFT];
    end
    if (rdy3) begin
      mask3_r <= mask2_r;
      gray3_r <= gray2_r;
      q3_r    <= Q_W'(x2_r) * Q_W'(RECIP_MULT);
    end
  end

  assign lvl_valid  = v3_r;
  assign lvl.mask   = mask3_r;
  assign lvl.level  = color_mode ? q3_r[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT] : gray3_r;

endmodule

>>> hdl/mplc_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_match
// Range compare against each enabled phase below the phase count, highest
// matching phase wins; registered result stage driving the output channel.
// ----------------------------------------------------------------------------
module mplc_match
  import mplc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  phase_cfg_t  pcfg,
  input  logic        lvl_valid,
  output logic        lvl_ready,
  input  lvl_t        lvl,
  mplc_out_if.source  out_res
);

  logic                valid_r;
  logic [CODE_W-1:0]   code_r;
  logic [CODE_W-1:0]   code_nxt;
  logic                win;
  logic [PHASE_W-1:0]  win_idx;

  assign lvl_ready = !valid_r || out_res.ready;

  always_comb begin
    win     = 1'b0;
    win_idx = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if ((COUNT_W'(p) < pcfg.count) && pcfg.enable[p] &&
          (lvl.level >= pcfg.lows[p]) && (lvl.level <= pcfg.highs[p])) begin
        win     = 1'b1;
        win_idx = PHASE_W'(p);
      end
    end
    code_nxt = (lvl.mask && win) ? (PHASE_BASE + CODE_W'(win_idx)) : CODE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (lvl_ready) begin
      valid_r <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_ready) begin
      code_r <= code_nxt;
    end
  end

  assign out_res.valid      = valid_r;
  assign out_res.phase_code = code_r;

endmodule

>>> hdl/multi_phase_level_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_phase_level_classifier_core
// Classifies each pixel into the highest-numbered enabled phase below the
// phase count whose inclusive level range holds the pixel's 8-bit level.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : pixel transactions (mask bit, red/gray, green, blue channels).
//   out_res : one phase_code per pixel transaction, in order; 0 when the pixel
//             is masked or no phase matches, else 0x80 + phase number.
//   cfg_*   : register writes (color mode, phase count, enables, low and high
//             byte arrays), taken on any cycle with cfg_we high; write only
//             while no transaction is in flight.
// Pixels pass from the accepting edge to out_res.valid through four register
// stages: products, sum and scale, reciprocal multiply, then compare
// and output register. Throughput is one pixel per clock. Each stage holds
// its own valid bit and advances when the stage after it is empty or moving,
// so bubbles close up while the receiver stalls; in_pix.ready drops only when
// all four stages are full and out_res is held.
// Synchronous reset clears config and valid bits and empties the pipeline.
// ----------------------------------------------------------------------------
module multi_phase_level_classifier_core
  import mplc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mplc_in_if.sink               in_pix,
  mplc_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                                color_mode_r;
  logic [COUNT_W-1:0]                  phase_count_r;
  logic [NUM_PHASES-1:0]               phase_enable_r;
  logic [NUM_PHASES-1:0][LEVEL_W-1:0]  phase_lows_r;
  logic [NUM_PHASES-1:0][LEVEL_W-1:0]  phase_highs_r;
  phase_cfg_t                          pcfg;
  logic                                lvl_valid;
  logic                                lvl_ready;
  lvl_t                                lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= 1'b0;
      phase_count_r  <= '0;
      phase_enable_r <= '0;
      phase_lows_r   <= '0;
      phase_highs_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COLOR_MODE:   color_mode_r   <= cfg_wdata[0];
        CFG_PHASE_COUNT:  phase_count_r  <= cfg_wdata[COUNT_W-1:0];
        CFG_PHASE_ENABLE: phase_enable_r <= cfg_wdata[NUM_PHASES-1:0];
        CFG_PHASE_LOWS:   phase_lows_r   <= cfg_wdata[NUM_PHASES*LEVEL_W-1:0];
        CFG_PHASE_HIGHS:  phase_highs_r  <= cfg_wdata[NUM_PHASES*LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign pcfg.count  = phase_count_r;
  assign pcfg.enable = phase_enable_r;
  assign pcfg.lows   = phase_lows_r;
  assign pcfg.highs  = phase_highs_r;

  mplc_level u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .color_mode (color_mode_r),
    .in_pix     (in_pix),
    .lvl_valid  (lvl_valid),
    .lvl_ready  (lvl_ready),
    .lvl        (lvl)
  );

  mplc_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .pcfg       (pcfg),
    .lvl_valid  (lvl_valid),
    .lvl_ready  (lvl_ready),
    .lvl        (lvl),
    .out_res    (out_res)
  );

  // nonzero code names an enabled phase below the phase count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.phase_code != CODE_NONE) |->
      (out_res.phase_code[CODE_W-1] &&
       out_res.phase_code[CODE_W-2:PHASE_W] == '0 &&
       phase_enable_r[out_res.phase_code[PHASE_W-1:0]] &&
       COUNT_W'(out_res.phase_code[PHASE_W-1:0]) < phase_count_r))
    else $error("phase code names a disabled or uncounted phase");

  // input backpressure only when the output is held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (out_res.valid && !out_res.ready))
    else $error("input stalled while output not blocked");

  // no phases configured: every result is zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && (phase_count_r == '0 || phase_enable_r == '0)) |->
      out_res.phase_code == CODE_NONE)
    else $error("nonzero code with no phases configured");

endmodule

>>> verif/tb_multi_phase_level_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_phase_level_classifier_core
// Self-checking testbench for the multi-phase level classifier core. Pixel
// transactions are sent in random bursts while the result side stalls on its
// own pattern. Each accepted pixel is classified by a local predictor that
// uses a copy of the register settings, and each result is checked in order.
// Directed tests cover the level extremes, both color modes, masking,
// overlapping, empty and disabled ranges and phase count saturation. A long
// result hold-off fills the pipeline, then random pixels run under several
// register settings.
// ----------------------------------------------------------------------------
module tb_multi_phase_level_classifier_core;
  import mplc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTING_ITEMS = 85;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mplc_in_if  pix_if ();
  mplc_out_if res_if ();

  multi_phase_level_classifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copy used by the predictor
  logic                             cur_color_mode;
  logic [COUNT_W-1:0]               cur_phase_count;
  logic [NUM_PHASES-1:0]            cur_phase_enable;
  logic [NUM_PHASES*LEVEL_W-1:0]    cur_phase_lows;
  logic [NUM_PHASES*LEVEL_W-1:0]    cur_phase_highs;

  logic [CODE_W-1:0] exp_codes[$];
  int                err_cnt;
  int                pixel_cnt;
  int                result_cnt;
  int                setting_cnt;
  int                cycle_cnt;
  int                burst_left;
  bit                tx_gap_en;
  int                hold_req;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, exp_codes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] classify_pixel(input logic mask,
                                                       input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b);
    int unsigned       bright;
    logic [LEVEL_W-1:0] lvl;
    int unsigned       n;
    logic [CODE_W-1:0] code;
    code = CODE_NONE;
    if (!mask) return code;
    if (cur_color_mode) begin
      bright = (int'(r) * 60 + int'(g) * 118 + int'(b) * 22) / 200;
      lvl    = LEVEL_W'(bright >> 8);
    end else begin
      lvl = r[CHAN_W-1 -: LEVEL_W];
    end
    n = (cur_phase_count > NUM_PHASES) ? NUM_PHASES : cur_phase_count;
    for (int p = 0; p < n; p++) begin
      if (cur_phase_enable[p] && lvl >= cur_phase_lows[8*p +: 8] &&
          lvl <= cur_phase_highs[8*p +: 8])
        code = PHASE_BASE + CODE_W'(p);
    end
    return code;
  endfunction

  // result checker
  always @(posedge clk) begin
    logic [CODE_W-1:0] want;
    if (rst_n && res_if.valid && res_if.ready) begin
      result_cnt <= result_cnt + 1;
      if (exp_codes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got phase_code %02h",
                 $time, res_if.phase_code);
        err_cnt <= err_cnt + 1;
      end else begin
        want = exp_codes.pop_front();
        if (res_if.phase_code !== want) begin
          $display("%0t: phase_code mismatch, expected %02h, got %02h",
                   $time, want, res_if.phase_code);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  // receiver: stall pattern in segments, plus requested long hold-offs
  initial begin
    int hold_left;
    int seg_left;
    int stall_pct;
    hold_left    = 0;
    seg_left     = 0;
    stall_pct    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        res_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_pixel(input logic mask, input logic [CHAN_W-1:0] r,
                            input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
    int gap;
    @(negedge clk);
    if (tx_gap_en && burst_left == 0) begin
      pix_if.valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    pix_if.pixel_valid = mask;
    pix_if.chan_red    = r;
    pix_if.chan_green  = g;
    pix_if.chan_blue   = b;
    pix_if.valid       = 1'b1;
    do @(posedge clk); while (!pix_if.ready);
    exp_codes.push_back(classify_pixel(mask, r, g, b));
    pixel_cnt++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (exp_codes.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_COLOR_MODE:   cur_color_mode   = val[0];
      CFG_PHASE_COUNT:  cur_phase_count  = val[COUNT_W-1:0];
      CFG_PHASE_ENABLE: cur_phase_enable = val[NUM_PHASES-1:0];
      CFG_PHASE_LOWS:   cur_phase_lows   = val;
      CFG_PHASE_HIGHS:  cur_phase_highs  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(input logic mode, input logic [COUNT_W-1:0] count,
                               input logic [NUM_PHASES-1:0] en,
                               input logic [CFG_DATA_W-1:0] lows,
                               input logic [CFG_DATA_W-1:0] highs);
    set_reg(CFG_COLOR_MODE, CFG_DATA_W'(mode));
    set_reg(CFG_PHASE_COUNT, CFG_DATA_W'(count));
    set_reg(CFG_PHASE_ENABLE, CFG_DATA_W'(en));
    set_reg(CFG_PHASE_LOWS, lows);
    set_reg(CFG_PHASE_HIGHS, highs);
    setting_cnt++;
  endtask

  // phase p gets [p*step, p*step + width - 1]
  function automatic void tiled_bands(input int step, input int width,
                                      output logic [CFG_DATA_W-1:0] lows,
                                      output logic [CFG_DATA_W-1:0] highs);
    for (int p = 0; p < NUM_PHASES; p++) begin
      lows[8*p +: 8]  = LEVEL_W'(p * step);
      highs[8*p +: 8] = LEVEL_W'(p * step + width - 1);
    end
  endfunction

  function automatic void random_bands(output logic [CFG_DATA_W-1:0] lows,
                                       output logic [CFG_DATA_W-1:0] highs);
    int lo;
    int hi;
    for (int p = 0; p < NUM_PHASES; p++) begin
      lo = $urandom_range(0, 255);
      hi = lo + $urandom_range(0, 80);
      if (hi > 255) hi = 255;
      if ($urandom_range(0, 7) == 0) hi = $urandom_range(0, 255);
      lows[8*p +: 8]  = LEVEL_W'(lo);
      highs[8*p +: 8] = LEVEL_W'(hi);
    end
  endfunction

  task automatic send_random_pixel();
    logic [CHAN_W-1:0] r;
    r = CHAN_W'($urandom);
    if ($urandom_range(0, 3) == 0)
      send_pixel($urandom_range(0, 9) != 0, r, r, r);
    else
      send_pixel($urandom_range(0, 9) != 0, r, CHAN_W'($urandom), CHAN_W'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_pixel(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_gray_levels();
    logic [CFG_DATA_W-1:0] lows;
    logic [CFG_DATA_W-1:0] highs;
    tiled_bands(32, 32, lows, highs);
    apply_setting(1'b0, 4'd8, 8'hFF, lows, highs);
    send_pixel(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b1, 16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'h00FF, 16'hAAAA, 16'h5555);
    send_pixel(1'b1, 16'h8000, 16'h5555, 16'hAAAA);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_rgb_levels();
    logic [CFG_DATA_W-1:0] lows;
    logic [CFG_DATA_W-1:0] highs;
    tiled_bands(32, 32, lows, highs);
    apply_setting(1'b1, 4'd8, 8'hFF, lows, highs);
    send_pixel(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_special_cases();
    logic [CFG_DATA_W-1:0] lows;
    logic [CFG_DATA_W-1:0] highs;
    // overlapping ranges, then top phase disabled
    apply_setting(1'b0, 4'd8, 8'hFF, '0, '1);
    send_pixel(1'b1, 16'h1234, 16'h0000, 16'h0000);
    set_reg(CFG_PHASE_ENABLE, CFG_DATA_W'(8'h7F));
    send_pixel(1'b1, 16'h1234, 16'h0000, 16'h0000);
    // count saturation and zero count
    set_reg(CFG_PHASE_ENABLE, CFG_DATA_W'(8'hFF));
    set_reg(CFG_PHASE_COUNT, CFG_DATA_W'(4'd15));
    send_pixel(1'b1, 16'hC3C3, 16'h0000, 16'h0000);
    set_reg(CFG_PHASE_COUNT, CFG_DATA_W'(4'd0));
    send_pixel(1'b1, 16'hC3C3, 16'h0000, 16'h0000);
    // empty ranges, phase 0 alone non-empty
    apply_setting(1'b0, 4'd8, 8'hFF, {8{8'h50}}, {8{8'h40}});
    send_pixel(1'b1, 16'h4500, 16'h0000, 16'h0000);
    set_reg(CFG_PHASE_HIGHS, {{7{8'h40}}, 8'h60});
    send_pixel(1'b1, 16'h4500, 16'h0000, 16'h0000);
    // gaps between ranges
    tiled_bands(32, 16, lows, highs);
    apply_setting(1'b0, 4'd8, 8'hFF, lows, highs);
    send_pixel(1'b1, 16'h1400, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'h2800, 16'h0000, 16'h0000);
  endtask

  task automatic test_output_backpressure();
    logic [CFG_DATA_W-1:0] lows;
    logic [CFG_DATA_W-1:0] highs;
    random_bands(lows, highs);
    apply_setting(1'b0, 4'd8, 8'hFF, lows, highs);
    hold_req  = 100;
    tx_gap_en = 1'b0;
    repeat (40) send_random_pixel();
    tx_gap_en = 1'b1;
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] lows;
    logic [CFG_DATA_W-1:0] highs;
    for (int s = 0; s < 8; s++) begin
      random_bands(lows, highs);
      case (s)
        0: apply_setting(1'b0, 4'd8, 8'hFF, '0, '1);
        1: apply_setting(1'b1, 4'd15, 8'($urandom), lows, highs);
        2: apply_setting(1'b0, 4'd0, 8'hFF, lows, highs);
        3: begin
          tiled_bands(32, 32, lows, highs);
          apply_setting(1'b1, 4'd8, 8'hFF, lows, highs);
        end
        4: apply_setting(1'b0, 4'($urandom_range(1, 7)), 8'($urandom), lows, highs);
        5: apply_setting(1'b1, 4'd8, 8'h00, lows, highs);
        6: apply_setting(1'b0, 4'd8, 8'hFF, '1, '1);
        default: apply_setting(1'b1, 4'($urandom_range(0, 15)), 8'($urandom),
                               lows, highs);
      endcase
      repeat (SETTING_ITEMS) send_random_pixel();
    end
  endtask

  initial begin
    cycle_cnt          = 0;
    err_cnt            = 0;
    pixel_cnt          = 0;
    result_cnt         = 0;
    setting_cnt        = 0;
    burst_left         = 0;
    tx_gap_en          = 1'b1;
    hold_req           = 0;
    cur_color_mode     = 1'b0;
    cur_phase_count    = '0;
    cur_phase_enable   = '0;
    cur_phase_lows     = '0;
    cur_phase_highs    = '0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_COLOR_MODE;
    cfg_wdata          = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_valid = 1'b0;
    pix_if.chan_red    = '0;
    pix_if.chan_green  = '0;
    pix_if.chan_blue   = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_gray_levels();
    test_rgb_levels();
    test_special_cases();
    test_output_backpressure();
    test_random_settings();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d pixels under %0d register settings, gray and RGB modes,",
             pixel_cnt, setting_cnt);
    $display("phase counts 0 to 15 and a long result hold-off; %0d results checked.",
             result_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
